// ===== design/position_pid_with_deadband_defines.svh =====
// Assertion macros for the position PID block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef POSITION_PID_WITH_DEADBAND_DEFINES_SVH
`define POSITION_PID_WITH_DEADBAND_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define PPID_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// Next-cycle implication, masked during reset.
`define PPID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

// ===== design/ppid_pkg.sv =====
// Shared types, widths and constants for the position PID block.
// No dependencies; the design modules and interfaces refer to it by scoped names, the bench imports it.
`timescale 1ns / 1ps

package ppid_pkg;

	localparam int GAIN_W      = 16;
	localparam int INTEG_WIDTH = 24;
	localparam int ERR_W       = 11;
	localparam int DE_W        = 12;
	localparam int POS_W       = 10;
	localparam int TGT_W       = 9;
	localparam int DRV_W       = 9;
	localparam int PWM_W       = 8;
	localparam int ANGLE_W     = 11;
	localparam int COUNT_W     = 32;

	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + INTEG_WIDTH;
	localparam int PROD_D_W = GAIN_W + DE_W;
	localparam int SUM_W    = PROD_I_W + 2;

	// Angle wrap and controller limits
	localparam int ANGLE_HI   = 179;
	localparam int ANGLE_LO   = -180;
	localparam int TURN       = 360;
	localparam int DRIVE_MAX  = 255;
	localparam int DEADBAND   = 2;
	localparam int DRIVE_FRAC = 8;
	localparam int GAIN_PROP_RESET = 256;

	// Remainder by 360 = 8 * 45: the low three bits pass, the rest goes mod 45.
	localparam int          DIV_MINOR   = 45;
	localparam int          RED_W       = 28;
	localparam int          RECIP_SHIFT = 33;
	localparam int          QUOT_W      = 22;
	localparam int          REM_W       = 7;
	localparam logic [27:0] RECIP_MINOR = 28'd190887435;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic MODE_SETPOINT = 1'b0;
	localparam logic MODE_SAMPLE   = 1'b1;

	typedef enum logic [1:0] {
		REG_GAIN_PROP  = 2'd0,
		REG_GAIN_INTEG = 2'd1,
		REG_GAIN_DERIV = 2'd2
	} cfg_reg_t;

	typedef logic signed [GAIN_W-1:0]      gain_t;
	typedef logic signed [ERR_W-1:0]       err_t;
	typedef logic signed [DE_W-1:0]        de_t;
	typedef logic signed [POS_W-1:0]       pos_t;
	typedef logic signed [TGT_W-1:0]       tgt_t;
	typedef logic signed [DRV_W-1:0]       drive_t;
	typedef logic signed [INTEG_WIDTH-1:0] integ_t;
	typedef logic signed [INTEG_WIDTH:0]   integ_ext_t;
	typedef logic signed [PROD_P_W-1:0]    prod_p_t;
	typedef logic signed [PROD_I_W-1:0]    prod_i_t;
	typedef logic signed [PROD_D_W-1:0]    prod_d_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic [FIFO_AW-1:0]            fifo_ptr_t;
	typedef logic [FIFO_AW:0]              fifo_cnt_t;

	localparam integ_ext_t INTEG_MAX = {2'b00, {(INTEG_WIDTH-1){1'b1}}};
	localparam integ_ext_t INTEG_MIN = {2'b11, {(INTEG_WIDTH-1){1'b0}}};

	// One classified word in the queue: a wrapped target or a shaft angle.
	typedef struct packed {
		logic mode;
		pos_t value;
	} fifo_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== design/ppid_channels.sv =====
// Handshake channels of the position PID block: samples in, results out, gain writes.
// Depends on ppid_pkg for field widths.
`timescale 1ns / 1ps

interface ppid_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 mode;
	logic signed [ppid_pkg::ANGLE_W-1:0] angle_request;
	logic signed [ppid_pkg::COUNT_W-1:0] encoder_count;
	modport source (output valid, mode, angle_request, encoder_count, input ready);
	modport sink (input valid, mode, angle_request, encoder_count, output ready);
endinterface

interface ppid_out_if;
	logic                   valid;
	logic                   ready;
	ppid_pkg::drive_t       drive;
	logic                   dir_a;
	logic                   dir_b;
	logic [ppid_pkg::PWM_W-1:0] pwm_level;
	ppid_pkg::pos_t         position;
	logic                   settled;
	modport source (output valid, drive, dir_a, dir_b, pwm_level, position, settled,
		input ready);
	modport sink (input valid, drive, dir_a, dir_b, pwm_level, position, settled,
		output ready);
endinterface

interface ppid_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  index;
	logic [ppid_pkg::GAIN_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/position_pid_with_deadband.sv =====
// Top level of the position PID controller with deadband.
// Depends on ppid_pkg, ppid_channels, ppid_fifo, ppid_front, ppid_back and the defines header.
//
// channel | dir | word carried                                   | taken when
// item    | in  | mode, angle_request, encoder_count             | valid && ready
// result  | out | drive, dir_a, dir_b, pwm_level, position, settled | valid && ready
// cfg     | in  | index (0 prop, 1 integ, 2 deriv), data         | valid && ready (always ready)
//
// A word taken by the front passes stages s1 to s4 into the queue, is popped when the back
//   is idle, then passes ST_MUL and ST_SUM before its result loads. A driving or braking
//   sample holds the back through state update, multiply, sum and clamp (ST_SUM waits on a
//   stalled output); setpoints and dropped samples are taken in idle alone.
// Reset clears the pipeline, queue, controller state and output register, and loads gains.
// A stalled result holds the output register; the back waits, the queue fills, then
//   item.ready drops.
`timescale 1ns / 1ps
`include "position_pid_with_deadband_defines.svh"

module position_pid_with_deadband (
	input  logic       clk,
	input  logic       arst_n,
	ppid_in_if.sink    item,
	ppid_out_if.source result,
	ppid_cfg_if.sink   cfg
);

	// queue between front and back
	logic                  push;
	logic                  pop;
	ppid_pkg::fifo_entry_t push_entry;
	ppid_pkg::fifo_entry_t head;
	ppid_pkg::fifo_stat_t  q_stat;

	// Front: classify each word, wrap setpoints, reduce counts to angles.
	ppid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.push_entry (push_entry),
		.q_stat     (q_stat)
	);

	// Queue: decouple front and back so each can stall alone.
	ppid_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// Back: advance the controller state one word at a time and present results.
	ppid_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.result (result),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	// Front holds only on a full queue.
	`PPID_ASSERT_IMPL(a_stall_only_full, !item.ready, q_stat.full)
	// A settled result is a brake: no drive, both legs high.
	`PPID_ASSERT_IMPL(a_brake_shape, result.valid && result.settled, (result.drive == '0) && result.dir_a && result.dir_b && (result.pwm_level == '0))
	// A driving result sets exactly one bridge leg.
	`PPID_ASSERT_IMPL(a_drive_legs, result.valid && !result.settled, result.dir_a != result.dir_b)
	// Taking a setpoint never produces a result.
	`PPID_ASSERT_NEXT(a_setpoint_silent, pop && (head.mode == ppid_pkg::MODE_SETPOINT) && !result.valid, !result.valid)

endmodule

// ===== design/ppid_fifo.sv =====
// Four-word queue between the front pipeline and the back sequencer.
// Depends on ppid_pkg for the entry and status types.
`timescale 1ns / 1ps

module ppid_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ppid_pkg::fifo_entry_t push_entry,
	input  logic                  pop,
	output ppid_pkg::fifo_entry_t head,
	output ppid_pkg::fifo_stat_t  stat
);

	ppid_pkg::fifo_entry_t mem_q [ppid_pkg::FIFO_DEPTH];
	ppid_pkg::fifo_ptr_t   wr_ptr_q;
	ppid_pkg::fifo_ptr_t   rd_ptr_q;
	ppid_pkg::fifo_cnt_t   count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == ppid_pkg::fifo_cnt_t'(ppid_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/ppid_front.sv =====
// Front pipeline: takes input words, wraps setpoints, turns encoder counts into angles.
// Depends on ppid_pkg and ppid_channels; feeds ppid_fifo.
`timescale 1ns / 1ps

module ppid_front (
	input  logic                  clk,
	input  logic                  arst_n,
	ppid_in_if.sink               item,
	output logic                  push,
	output ppid_pkg::fifo_entry_t push_entry,
	input  ppid_pkg::fifo_stat_t  q_stat
);

	logic advance;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic mode_s1, mode_s2, mode_s3, mode_s4;
	ppid_pkg::tgt_t tgt_s1, tgt_s2, tgt_s3, tgt_s4;
	logic [30:0] q_s1;
	logic [ppid_pkg::RED_W-1:0] b_s2;
	logic [2:0] low3_s2, low3_s3, low3_s4;
	logic neg_s2, neg_s3, neg_s4;
	logic [ppid_pkg::QUOT_W-1:0] qe_s3;
	logic [ppid_pkg::REM_W-1:0] blow_s3;
	logic [ppid_pkg::REM_W-1:0] r7_s4;

	logic signed [11:0] ang_ext;
	logic signed [11:0] ang_wrap;
	logic signed [ppid_pkg::COUNT_W-1:0] half;
	logic [30:0] q_next;
	logic [30:0] abs_q;
	logic [ppid_pkg::RED_W+27:0] prod;
	logic [ppid_pkg::REM_W-1:0] m45;
	logic [5:0] rem45;
	logic [8:0] mag;
	ppid_pkg::pos_t pos;

	// Whole pipe moves together; hold only when the last stage cannot push.
	assign advance    = !valid_s4 || !q_stat.full;
	assign item.ready = advance;
	assign push       = valid_s4 && !q_stat.full;

	always_comb begin
		ang_ext = {item.angle_request[ppid_pkg::ANGLE_W-1], item.angle_request};
		if (ang_ext > ppid_pkg::ANGLE_HI) begin
			ang_wrap = ang_ext - 12'(ppid_pkg::TURN);
		end else if (ang_ext < ppid_pkg::ANGLE_LO) begin
			ang_wrap = ang_ext + 12'(ppid_pkg::TURN);
		end else begin
			ang_wrap = ang_ext;
		end
		// truncating halve: round negative odd counts toward zero
		half   = item.encoder_count >>> 1;
		q_next = half[30:0] + 31'(item.encoder_count[31] & item.encoder_count[0]);
	end

	assign abs_q = q_s1[30] ? (~q_s1 + 31'd1) : q_s1;
	assign prod  = (ppid_pkg::RED_W+28)'(b_s2) * (ppid_pkg::RED_W+28)'(ppid_pkg::RECIP_MINOR);
	assign m45   = ppid_pkg::REM_W'(qe_s3[ppid_pkg::REM_W-1:0] *
		ppid_pkg::REM_W'(ppid_pkg::DIV_MINOR));

	always_comb begin
		if (r7_s4 >= ppid_pkg::REM_W'(ppid_pkg::DIV_MINOR)) begin
			rem45 = 6'(r7_s4 - ppid_pkg::REM_W'(ppid_pkg::DIV_MINOR));
		end else begin
			rem45 = r7_s4[5:0];
		end
		mag = {rem45, low3_s4};
		pos = neg_s4 ? -ppid_pkg::pos_t'(mag) : ppid_pkg::pos_t'(mag);
		push_entry.mode  = mode_s4;
		push_entry.value = (mode_s4 == ppid_pkg::MODE_SAMPLE) ? pos :
			ppid_pkg::pos_t'(tgt_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s1 <= item.mode;
			tgt_s1  <= ang_wrap[ppid_pkg::TGT_W-1:0];
			q_s1    <= q_next;

			mode_s2 <= mode_s1;
			tgt_s2  <= tgt_s1;
			neg_s2  <= q_s1[30];
			b_s2    <= abs_q[30:3];
			low3_s2 <= abs_q[2:0];

			mode_s3 <= mode_s2;
			tgt_s3  <= tgt_s2;
			neg_s3  <= neg_s2;
			low3_s3 <= low3_s2;
			qe_s3   <= prod[ppid_pkg::RECIP_SHIFT +: ppid_pkg::QUOT_W];
			blow_s3 <= b_s2[ppid_pkg::REM_W-1:0];

			mode_s4 <= mode_s3;
			tgt_s4  <= tgt_s3;
			neg_s4  <= neg_s3;
			low3_s4 <= low3_s3;
			r7_s4   <= blow_s3 - m45;
		end
	end

endmodule

// ===== design/ppid_back.sv =====
// Back sequencer: controller state, gain registers, PID sum, clamp and result register.
// Depends on ppid_pkg and ppid_channels; drains ppid_fifo.
`timescale 1ns / 1ps

module ppid_back (
	input  logic                  clk,
	input  logic                  arst_n,
	ppid_cfg_if.sink              cfg,
	ppid_out_if.source            result,
	output logic                  pop,
	input  ppid_pkg::fifo_entry_t head,
	input  ppid_pkg::fifo_stat_t  q_stat
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_SUM  = 3'b100
	} seq_state_t;

	seq_state_t state_q;

	ppid_pkg::gain_t  gain_prop_q, gain_integ_q, gain_deriv_q;
	ppid_pkg::tgt_t   target_q;
	ppid_pkg::integ_t integ_q;
	ppid_pkg::err_t   prev_err_q;
	logic             active_q;

	ppid_pkg::err_t  err_s1;
	ppid_pkg::de_t   de_s1;
	logic            brake_s1;
	ppid_pkg::pos_t  pos_s1;
	ppid_pkg::prod_p_t prod_p_s2;
	ppid_pkg::prod_i_t prod_i_s2;
	ppid_pkg::prod_d_t prod_d_s2;

	logic                       res_valid_q;
	ppid_pkg::drive_t           drive_q;
	logic                       dir_a_q, dir_b_q, settled_q;
	logic [ppid_pkg::PWM_W-1:0] pwm_q;
	ppid_pkg::pos_t             position_q;

	logic                 out_load;
	ppid_pkg::err_t       err;
	ppid_pkg::de_t        de;
	logic                 drive_on;
	ppid_pkg::integ_ext_t isum;
	ppid_pkg::integ_t     isat;
	ppid_pkg::sum_t       raw;
	ppid_pkg::sum_t       shr;
	ppid_pkg::drive_t     drv;

	assign cfg.ready = 1'b1;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_load  = !res_valid_q || result.ready;

	always_comb begin
		err = ppid_pkg::err_t'(target_q) - ppid_pkg::err_t'(head.value);
		de  = ppid_pkg::de_t'(err) - ppid_pkg::de_t'(prev_err_q);
		drive_on = (err > ppid_pkg::err_t'(ppid_pkg::DEADBAND)) ||
			((err < -ppid_pkg::err_t'(ppid_pkg::DEADBAND)) && (target_q != '0));
		isum = ppid_pkg::integ_ext_t'(integ_q) + ppid_pkg::integ_ext_t'(err);
		if (isum > ppid_pkg::INTEG_MAX) begin
			isat = ppid_pkg::integ_t'(ppid_pkg::INTEG_MAX);
		end else if (isum < ppid_pkg::INTEG_MIN) begin
			isat = ppid_pkg::integ_t'(ppid_pkg::INTEG_MIN);
		end else begin
			isat = ppid_pkg::integ_t'(isum);
		end
	end

	always_comb begin
		raw = ppid_pkg::sum_t'(prod_p_s2) + ppid_pkg::sum_t'(prod_i_s2) +
			ppid_pkg::sum_t'(prod_d_s2);
		shr = raw >>> ppid_pkg::DRIVE_FRAC;
		if (shr > ppid_pkg::sum_t'(ppid_pkg::DRIVE_MAX)) begin
			drv = ppid_pkg::drive_t'(ppid_pkg::DRIVE_MAX);
		end else if (shr < -ppid_pkg::sum_t'(ppid_pkg::DRIVE_MAX)) begin
			drv = -ppid_pkg::drive_t'(ppid_pkg::DRIVE_MAX);
		end else begin
			drv = ppid_pkg::drive_t'(shr);
		end
	end

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= ppid_pkg::gain_t'(ppid_pkg::GAIN_PROP_RESET);
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ppid_pkg::REG_GAIN_PROP:  gain_prop_q  <= cfg.data;
				ppid_pkg::REG_GAIN_INTEG: gain_integ_q <= cfg.data;
				ppid_pkg::REG_GAIN_DERIV: gain_deriv_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= '0;
			integ_q     <= '0;
			prev_err_q  <= '0;
			active_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.mode == ppid_pkg::MODE_SETPOINT) begin
							target_q <= head.value[ppid_pkg::TGT_W-1:0];
							active_q <= 1'b1;
						end else if (active_q) begin
							prev_err_q <= err;
							if (drive_on) begin
								integ_q <= isat;
							end else begin
								integ_q  <= '0;
								active_q <= 1'b0;
							end
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if ((state_q == ST_SUM) && out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			err_s1   <= err;
			de_s1    <= de;
			brake_s1 <= !drive_on;
			pos_s1   <= head.value;
		end
		if (state_q == ST_MUL) begin
			prod_p_s2 <= gain_prop_q * err_s1;
			prod_i_s2 <= gain_integ_q * integ_q;
			prod_d_s2 <= gain_deriv_q * de_s1;
		end
		if ((state_q == ST_SUM) && out_load) begin
			position_q <= pos_s1;
			if (brake_s1) begin
				drive_q   <= '0;
				dir_a_q   <= 1'b1;
				dir_b_q   <= 1'b1;
				pwm_q     <= '0;
				settled_q <= 1'b1;
			end else begin
				drive_q   <= drv;
				dir_a_q   <= (drv > 0);
				dir_b_q   <= !(drv > 0);
				pwm_q     <= drv[ppid_pkg::DRV_W-1] ? ppid_pkg::PWM_W'(-drv) :
					drv[ppid_pkg::PWM_W-1:0];
				settled_q <= 1'b0;
			end
		end
	end

	assign result.valid     = res_valid_q;
	assign result.drive     = drive_q;
	assign result.dir_a     = dir_a_q;
	assign result.dir_b     = dir_b_q;
	assign result.pwm_level = pwm_q;
	assign result.position  = position_q;
	assign result.settled   = settled_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for the position PID block with deadband.
// Uses ppid_pkg, the channel interfaces in ppid_channels and the top position_pid_with_deadband.
`timescale 1ns / 1ps

module testbench;
	import ppid_pkg::*;

	// Index past the end of the gain list: the block must drop such a write.
	localparam logic [1:0] REG_SPARE = 2'd3;
	// Cycles to let setpoints or dropped samples drain out after the last result.
	localparam int DRAIN_CYCLES = 24;
	// Random words per gain setting.
	localparam int PHASE_WORDS = 260;
	// Words in the back-to-back stretch at the end.
	localparam int STEADY_WORDS = 100;

	typedef struct packed {
		drive_t           drive;
		logic             dir_a;
		logic             dir_b;
		logic [PWM_W-1:0] pwm_level;
		pos_t             position;
		logic             settled;
	} drive_word_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_HOLD} rx_pattern_e;

	// Tracks the controller state, turns each accepted word that yields a result into the
	// drive word that it should produce and checks the results in order.
	class drive_scoreboard;
		gain_t       kp;
		gain_t       ki;
		gain_t       kd;
		tgt_t        target;
		integ_t      integ;
		err_t        last_err;
		bit          moving;
		drive_word_t pending[$];
		int unsigned errors;
		int unsigned live_items;

		function new();
			kp = GAIN_PROP_RESET;
			ki = '0;
			kd = '0;
			target = '0;
			integ = '0;
			last_err = '0;
			moving = 1'b0;
			errors = 0;
			live_items = 0;
		endfunction

		function void load_gain(logic [1:0] idx, logic [GAIN_W-1:0] val);
			case (idx)
				REG_GAIN_PROP:  kp = val;
				REG_GAIN_INTEG: ki = val;
				REG_GAIN_DERIV: kd = val;
				default: ;
			endcase
		endfunction

		function void note_item(logic m, logic signed [ANGLE_W-1:0] a,
				logic signed [COUNT_W-1:0] c);
			longint      wrapped;
			longint      pos;
			longint      err;
			longint      de;
			longint      sum;
			longint      raw;
			longint      drv;
			longint      hi;
			drive_word_t w;
			if (m == MODE_SETPOINT) begin
				// Wrap once, then keep the low bits of the target register.
				wrapped = a;
				if (wrapped > ANGLE_HI)
					wrapped -= TURN;
				else if (wrapped < ANGLE_LO)
					wrapped += TURN;
				target = tgt_t'(wrapped);
				moving = 1'b1;
				live_items++;
				return;
			end
			// Samples outside a move change nothing.
			if (!moving)
				return;
			live_items++;
			pos = longint'(c) / 2;
			pos = pos % TURN;
			err = longint'(target) - pos;
			de = err - longint'(last_err);
			last_err = err_t'(err);
			if (err > DEADBAND || (err < -DEADBAND && target != 0)) begin
				hi = (longint'(1) << (INTEG_WIDTH - 1)) - 1;
				sum = longint'(integ) + err;
				if (sum > hi)
					sum = hi;
				else if (sum < -hi - 1)
					sum = -hi - 1;
				integ = integ_t'(sum);
				raw = longint'(kp) * err + longint'(ki) * longint'(integ) + longint'(kd) * de;
				// Arithmetic shift rounds toward minus infinity.
				drv = raw >>> DRIVE_FRAC;
				if (drv > DRIVE_MAX)
					drv = DRIVE_MAX;
				else if (drv < -DRIVE_MAX)
					drv = -DRIVE_MAX;
				w.drive = drive_t'(drv);
				w.dir_a = (drv > 0);
				w.dir_b = (drv <= 0);
				w.pwm_level = (drv < 0) ? PWM_W'(-drv) : PWM_W'(drv);
				w.settled = 1'b0;
			end else begin
				// Deadband reached: brake, clear the integral, end the move.
				integ = '0;
				moving = 1'b0;
				w.drive = '0;
				w.dir_a = 1'b1;
				w.dir_b = 1'b1;
				w.pwm_level = '0;
				w.settled = 1'b1;
			end
			w.position = pos_t'(pos);
			pending.push_back(w);
		endfunction

		function void match(string field, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(drive_word_t got);
			drive_word_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, drive %0d position %0d", $time,
					got.drive, got.position);
				return;
			end
			want = pending.pop_front();
			match("drive", want.drive, got.drive);
			match("dir_a", want.dir_a, got.dir_a);
			match("dir_b", want.dir_b, got.dir_b);
			match("pwm_level", want.pwm_level, got.pwm_level);
			match("position", want.position, got.position);
			match("settled", want.settled, got.settled);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ppid_in_if  in_ch ();
	ppid_out_if out_ch ();
	ppid_cfg_if cfg_ch ();

	drive_scoreboard ledger;
	drive_word_t     seen;
	int              burst_left;
	bit              steady;
	bit              squeeze_req;

	position_pid_with_deadband dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#12_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Watch all three channels at the rising edge; a word moves when valid and ready
	// are both high. Gain writes land first so the predictor sees them in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				ledger.load_gain(cfg_ch.index, cfg_ch.data);
			if (in_ch.valid && in_ch.ready)
				ledger.note_item(in_ch.mode, in_ch.angle_request, in_ch.encoder_count);
			if (out_ch.valid && out_ch.ready) begin
				seen.drive = out_ch.drive;
				seen.dir_a = out_ch.dir_a;
				seen.dir_b = out_ch.dir_b;
				seen.pwm_level = out_ch.pwm_level;
				seen.position = out_ch.position;
				seen.settled = out_ch.settled;
				ledger.check_result(seen);
			end
		end
	end

	// Result side pacing: random patterns, occasional long hold-offs, and one forced
	// squeeze that backs the block up until it drops item ready.
	initial begin : rx_pacer
		int          hold;
		int          span;
		bit          squeezed;
		rx_pattern_e pattern;
		hold = 0;
		span = 0;
		squeezed = 1'b0;
		pattern = RX_OPEN;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				hold = 300;
			end
			if (steady) begin
				out_ch.ready <= 1'b1;
			end else if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				if (span == 0) begin
					pattern = rx_pattern_e'($urandom_range(0, 3));
					span = $urandom_range(50, 400);
					if (pattern == RX_HOLD)
						hold = $urandom_range(100, 250);
				end
				span--;
				case (pattern)
					RX_OPEN:   out_ch.ready <= 1'b1;
					RX_COIN:   out_ch.ready <= 1'($urandom);
					RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 9) != 0);
					default:   out_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Offer one word and hold it until taken. Words go out in bursts; between bursts
	// drop valid for a random gap (none while steady).
	task automatic send_item(input logic m, input logic signed [ANGLE_W-1:0] a,
			input logic signed [COUNT_W-1:0] c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.angle_request <= a;
		in_ch.encoder_count <= c;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop valid, wait out every expected word, then let trailing setpoints drain.
	// Returns just after a rising edge.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(input logic [1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Load all three gains plus a junk write to the spare index, then release the port.
	task automatic write_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
			input logic [GAIN_W-1:0] d);
		write_gain(REG_GAIN_PROP, p);
		write_gain(REG_GAIN_INTEG, i);
		write_gain(REG_GAIN_DERIV, d);
		write_gain(REG_SPARE, GAIN_W'($urandom));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Encoder count that lands on a given shaft angle, with a random odd bit and,
	// now and then, whole extra turns of the same sign.
	function automatic int count_for(int pos);
		int c;
		int turns;
		c = 2 * pos;
		if ($urandom_range(0, 1))
			c += (pos < 0) ? -1 : 1;
		if ($urandom_range(0, 3) == 0) begin
			turns = $urandom_range(0, 2_900_000);
			c += ((pos < 0) ? -720 : 720) * turns;
		end
		return c;
	endfunction

	// Random moves: a setpoint, samples that close in on the target, usually a final
	// sample near the deadband edge. Some moves are cut short by the next setpoint, and
	// one pick in ten sends a single word of plain noise instead of a move.
	task automatic run_moves(input int unsigned quota);
		int unsigned stop_at;
		int          a;
		int          wrapped;
		int          t;
		int          n;
		int          reach;
		int          pos;
		tgt_t        tt;
		stop_at = ledger.live_items + quota;
		while (ledger.live_items < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(1'($urandom), ANGLE_W'($urandom), COUNT_W'($urandom));
			end else begin
				if ($urandom_range(0, 7) == 0)
					a = $urandom_range(0, 2047) - 1024;
				else
					a = $urandom_range(0, 359) - 180;
				send_item(MODE_SETPOINT, ANGLE_W'(a), COUNT_W'($urandom));
				wrapped = a;
				if (wrapped > ANGLE_HI)
					wrapped -= TURN;
				else if (wrapped < ANGLE_LO)
					wrapped += TURN;
				tt = tgt_t'(wrapped);
				t = tt;
				n = $urandom_range(1, 10);
				for (int k = 0; k < n; k++) begin
					reach = 200 * (n - k) / n;
					pos = t + $urandom_range(0, 2 * reach) - reach;
					if (pos > TURN - 1)
						pos = TURN - 1;
					else if (pos < 1 - TURN)
						pos = 1 - TURN;
					send_item(MODE_SAMPLE, ANGLE_W'($urandom), COUNT_W'(count_for(pos)));
				end
				// Land near the deadband edge most of the time.
				if ($urandom_range(0, 4) != 0) begin
					pos = t + $urandom_range(0, 8) - 4;
					send_item(MODE_SAMPLE, ANGLE_W'($urandom), COUNT_W'(count_for(pos)));
				end
			end
		end
	endtask

	initial begin
		ledger = new();
		burst_left = 0;
		steady = 1'b0;
		squeeze_req = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_SETPOINT;
		in_ch.angle_request = '0;
		in_ch.encoder_count = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_GAIN_PROP;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed words under the reset gains (pure proportional, unity).
		send_item(MODE_SAMPLE, 0, 100);                 // sample with no move: drop
		send_item(MODE_SETPOINT, 539, 0);               // top of range wraps to 179
		send_item(MODE_SAMPLE, 0, 32'sh7fffffff);       // largest count
		send_item(MODE_SAMPLE, 0, 32'sh80000000);       // smallest count, negative angle
		send_item(MODE_SETPOINT, -540, 0);              // new target during a move
		send_item(MODE_SAMPLE, 0, -1);                  // truncates to angle zero
		send_item(MODE_SAMPLE, 0, 719);                 // 359 degrees, drive clamps low
		send_item(MODE_SAMPLE, 0, -718);                // -359 degrees
		send_item(MODE_SAMPLE, 0, -360);                // on target: brake
		send_item(MODE_SAMPLE, 0, 5);                   // move over: drop
		send_item(MODE_SETPOINT, 0, 0);                 // zero target
		send_item(MODE_SAMPLE, 0, 6);                   // error -3 with zero target: brake
		send_item(MODE_SETPOINT, 1023, 0);              // field max, wraps past 9 bits
		send_item(MODE_SAMPLE, 0, 298);                 // error +2: brake
		send_item(MODE_SETPOINT, -1024, 0);             // field min
		send_item(MODE_SAMPLE, 0, -300);                // error -2: brake
		send_item(MODE_SETPOINT, 180, 0);               // just over the top: -180
		send_item(MODE_SAMPLE, 0, -354);                // error -3: drive
		send_item(MODE_SETPOINT, -181, 0);              // just under the bottom: 179
		send_item(MODE_SAMPLE, 0, 352);                 // error +3: drive
		send_item(MODE_SAMPLE, 0, 1);                   // large step in error
		settle();

		// Tiny proportional gain: small errors round to zero or minus one.
		write_gains(16'sd1, 16'sd0, 16'sd0);
		send_item(MODE_SETPOINT, 10, 0);
		send_item(MODE_SAMPLE, 0, 14);                  // drive rounds to zero
		send_item(MODE_SAMPLE, 0, 30);                  // error -5 floors to -1
		send_item(MODE_SAMPLE, 0, 20);                  // on target: brake
		settle();

		// Random phases over several gain settings, extremes included. The first one
		// opens with a long result hold-off so the block backs up.
		squeeze_req = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_gains(16'sd256, 16'sd16, 16'sd64);
				1: write_gains(16'sh7fff, 16'sh7fff, 16'sh7fff);
				2: write_gains(16'sh8000, 16'sh8000, 16'sh8000);
				3: write_gains(16'sd300, -16'sd5, -16'sd200);
				4: write_gains(16'sd1, 16'sd0, 16'sd0);
				default: write_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
			endcase
			run_moves(PHASE_WORDS);
			settle();
		end

		// Back-to-back stretch: offer words with no gaps and take every result at once.
		steady = 1'b1;
		write_gains(16'sd200, 16'sd3, 16'sd40);
		run_moves(STEADY_WORDS);
		settle();
		steady = 1'b0;

		if (ledger.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
